// ===== rtl/core/tpse_pkg.sv =====
`default_nettype none
package tpse_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned SYM_W    = 10;
  localparam int unsigned DISP_W   = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned ENTRY_W  = 8;

  // Channel order in all per-channel arrays
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  // colour_format codes
  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB888 = 1'b1;

  localparam logic [3:0] ONES_BALANCED = 4'd4;

  // Channel byte with its XOR/XNOR decision
  typedef struct packed {
    logic [CHAN_W-1:0] d;
    logic              use_xnor;
  } chan_t;

  // Transition-minimized word, bit 8 set for XOR
  typedef logic [CHAN_W:0] tm_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t pos;
    word_t neg;
  } sym_pair_t;

  function automatic logic [3:0] ones8(input logic [CHAN_W-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < CHAN_W; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tpse_unpack.sv =====
`default_nettype none
module tpse_unpack (
  input  wire logic                            colour_format,
  input  wire logic [tpse_pkg::COLOUR_W-1:0]   colour,
  output tpse_pkg::chan_t                      chan [tpse_pkg::NUM_CHAN]
);

  logic [tpse_pkg::CHAN_W-1:0] byte_w [tpse_pkg::NUM_CHAN];
  logic [3:0]                  ones_w [tpse_pkg::NUM_CHAN];

  always_comb begin
    if (colour_format == tpse_pkg::FMT_RGB888) begin
      byte_w[tpse_pkg::CH_BLUE]  = colour[7:0];
      byte_w[tpse_pkg::CH_GREEN] = colour[15:8];
      byte_w[tpse_pkg::CH_RED]   = colour[23:16];
    end else begin
      // widen 5/6/5 fields, low bits zero
      byte_w[tpse_pkg::CH_BLUE]  = {colour[4:0], 3'b000};
      byte_w[tpse_pkg::CH_GREEN] = {colour[10:5], 2'b00};
      byte_w[tpse_pkg::CH_RED]   = {colour[15:11], 3'b000};
    end
  end

  for (genvar c = 0; c < tpse_pkg::NUM_CHAN; c++) begin : g_chan
    assign ones_w[c]     = tpse_pkg::ones8(byte_w[c]);
    assign chan[c].d     = byte_w[c];
    // XNOR when more than four ones, or exactly four with bit 0 clear
    assign chan[c].use_xnor = (ones_w[c] > tpse_pkg::ONES_BALANCED) ||
                              ((ones_w[c] == tpse_pkg::ONES_BALANCED) && !byte_w[c][0]);
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpse_tm_word.sv =====
`default_nettype none
module tpse_tm_word (
  input  wire tpse_pkg::chan_t chan,
  output tpse_pkg::tm_t        q
);

  always_comb begin
    q    = '0;
    q[0] = chan.d[0];
    for (int i = 1; i < tpse_pkg::CHAN_W; i++) begin
      q[i] = q[i-1] ^ chan.d[i] ^ chan.use_xnor;
    end
    q[tpse_pkg::CHAN_W] = !chan.use_xnor;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tpse_pair.sv =====
`default_nettype none
module tpse_pair (
  input  wire tpse_pkg::tm_t q,
  output tpse_pkg::sym_pair_t pair
);

  logic [3:0]                  ones;
  logic                        b8;
  logic [tpse_pkg::SYM_W-1:0]  sym_plain;
  logic [tpse_pkg::SYM_W-1:0]  sym_inv;
  logic [tpse_pkg::SYM_W-1:0]  sym_bal;
  logic [tpse_pkg::DISP_W-1:0] imb;
  logic [tpse_pkg::DISP_W-1:0] d_plain;
  logic [tpse_pkg::DISP_W-1:0] d_inv;
  logic [15:0]                 gap;

  assign gap       = '0;
  assign ones      = tpse_pkg::ones8(q[7:0]);
  assign b8        = q[8];
  assign sym_plain = {1'b0, q};
  assign sym_inv   = {1'b1, b8, ~q[7:0]};
  // balanced: bit 9 is ~bit 8, data inverted when bit 8 clear
  assign sym_bal   = b8 ? sym_plain : sym_inv;

  // 2*ones - 8 over the data bits, 6-bit two's complement
  assign imb     = {1'b0, ones, 1'b0} - 6'd8;
  assign d_plain = b8 ? imb : (imb - 6'd2);
  assign d_inv   = b8 ? (6'd2 - imb) : (6'd0 - imb);

  always_comb begin
    if (ones == tpse_pkg::ONES_BALANCED) begin
      pair.neg = {6'd0, gap, sym_bal};
      pair.pos = {6'd0, gap, sym_bal};
    end else if (ones > tpse_pkg::ONES_BALANCED) begin
      pair.neg = {d_inv, gap, sym_inv};
      pair.pos = {d_plain, gap, sym_plain};
    end else begin
      pair.neg = {d_plain, gap, sym_plain};
      pair.pos = {d_inv, gap, sym_inv};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tmds_palette_symbol_pair_encoder.sv =====
`default_nettype none
// Channel | Dir | Handshake              | Payload
// in      | in  | in_tvalid / in_tready  | tdata: colour[23:0], entry_index[31:24]
// out     | out | out_tvalid / out_tready| tdata: entry_out, then six 32-bit words
// cfg     | in  | cfg_valid / cfg_ready  | colour_format, always ready
//
// Three register stages: unpack and XOR/XNOR choice, transition-minimized
// word, symbol pair with disparity. One transfer a cycle sustained while
// out_tready stays high. Synchronous active-low reset clears the stage valid
// bits and sets colour_format to RGB565. A stalled output holds its stage and
// bubbles ahead of it are filled, so no item is dropped or repeated.
module tmds_palette_symbol_pair_encoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [31:0]  in_tdata,   // colour[23:0], entry_index[31:24]
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // entry_out[7:0], blue_negative_word[39:8], blue_positive_word[71:40],
  // green_negative_word[103:72], green_positive_word[135:104],
  // red_negative_word[167:136], red_positive_word[199:168]
  output      logic [199:0] out_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic         cfg_data
);

  localparam int unsigned NC = tpse_pkg::NUM_CHAN;

  logic colour_format_r;

  logic adv1, adv2, adv3;
  logic v1_r, v2_r, v3_r;

  tpse_pkg::chan_t     chan_w   [NC];
  tpse_pkg::chan_t     chan_r   [NC];
  tpse_pkg::tm_t       tm_w     [NC];
  tpse_pkg::tm_t       tm_r     [NC];
  tpse_pkg::sym_pair_t pair_w   [NC];
  tpse_pkg::sym_pair_t pair_r   [NC];
  logic [tpse_pkg::ENTRY_W-1:0] entry1_r, entry2_r, entry3_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_format_r <= tpse_pkg::FMT_RGB565;
    end else if (cfg_valid && cfg_ready) begin
      colour_format_r <= cfg_data;
    end
  end

  // a stage advances when empty or when the one after it advances
  assign adv3      = !v3_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  tpse_unpack u_unpack (
    .colour_format (colour_format_r),
    .colour        (in_tdata[23:0]),
    .chan          (chan_w)
  );

  for (genvar c = 0; c < NC; c++) begin : g_chan
    tpse_tm_word u_tm (
      .chan (chan_r[c]),
      .q    (tm_w[c])
    );

    tpse_pair u_pair (
      .q    (tm_r[c]),
      .pair (pair_w[c])
    );

    always_ff @(posedge clk) begin
      if (adv1) begin
        chan_r[c] <= chan_w[c];
      end
      if (adv2) begin
        tm_r[c] <= tm_w[c];
      end
      if (adv3) begin
        pair_r[c] <= pair_w[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      entry1_r <= in_tdata[31:24];
    end
    if (adv2) begin
      entry2_r <= entry1_r;
    end
    if (adv3) begin
      entry3_r <= entry2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {pair_r[tpse_pkg::CH_RED].pos,   pair_r[tpse_pkg::CH_RED].neg,
                       pair_r[tpse_pkg::CH_GREEN].pos, pair_r[tpse_pkg::CH_GREEN].neg,
                       pair_r[tpse_pkg::CH_BLUE].pos,  pair_r[tpse_pkg::CH_BLUE].neg,
                       entry3_r};

endmodule
`default_nettype wire

// ===== test/symbol_pair_checker.sv =====
module symbol_pair_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [31:0]  in_tdata,   // colour[23:0], entry_index[31:24]
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // entry_out[7:0], blue_negative_word[39:8], blue_positive_word[71:40],
  // green_negative_word[103:72], green_positive_word[135:104],
  // red_negative_word[167:136], red_positive_word[199:168]
  input  wire logic [199:0] out_tdata,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic         cfg_data,
  output int                fail_count,
  output int                pending
);

  // Field order matches out_tdata, highest bits first
  typedef struct packed {
    tpse_pkg::word_t              red_pos;
    tpse_pkg::word_t              red_neg;
    tpse_pkg::word_t              green_pos;
    tpse_pkg::word_t              green_neg;
    tpse_pkg::word_t              blue_pos;
    tpse_pkg::word_t              blue_neg;
    logic [tpse_pkg::ENTRY_W-1:0] entry;
  } palette_words_t;

  logic           colour_format;
  palette_words_t expected_words[$];

  function automatic tpse_pkg::word_t pack_symbol(input logic [tpse_pkg::SYM_W-1:0] sym,
                                                  input logic [tpse_pkg::DISP_W-1:0] disp);
    return {disp, {(tpse_pkg::WORD_W-tpse_pkg::SYM_W-tpse_pkg::DISP_W){1'b0}}, sym};
  endfunction

  // Returns the negative/positive symbol pair for one channel byte
  function automatic tpse_pkg::sym_pair_t encode_tmds_pair(
    input logic [tpse_pkg::CHAN_W-1:0] d);
    logic [tpse_pkg::CHAN_W:0]   q;
    logic                        use_xnor;
    int                          imb;
    logic [tpse_pkg::SYM_W-1:0]  sym_plain;
    logic [tpse_pkg::SYM_W-1:0]  sym_inv;
    logic [tpse_pkg::DISP_W-1:0] disp_plain;
    logic [tpse_pkg::DISP_W-1:0] disp_inv;
    tpse_pkg::sym_pair_t         pair;
    use_xnor = ($countones(d) > 4) || ($countones(d) == 4 && !d[0]);
    q[0] = d[0];
    for (int i = 1; i < tpse_pkg::CHAN_W; i++) begin
      q[i] = q[i-1] ^ d[i] ^ use_xnor;
    end
    q[tpse_pkg::CHAN_W] = !use_xnor;
    imb = 2 * $countones(q[tpse_pkg::CHAN_W-1:0]) - 8;
    sym_plain = {1'b0, q};
    sym_inv = {1'b1, q[tpse_pkg::CHAN_W], ~q[tpse_pkg::CHAN_W-1:0]};
    if (imb == 0) begin
      // balanced: one symbol, data bits inverted only for the XNOR form
      pair.neg = pack_symbol(q[tpse_pkg::CHAN_W] ? sym_plain : sym_inv, '0);
      pair.pos = pair.neg;
      return pair;
    end
    disp_plain = tpse_pkg::DISP_W'(imb - (q[tpse_pkg::CHAN_W] ? 0 : 2));
    disp_inv = tpse_pkg::DISP_W'(-imb + (q[tpse_pkg::CHAN_W] ? 2 : 0));
    if (imb > 0) begin
      pair.neg = pack_symbol(sym_inv, disp_inv);
      pair.pos = pack_symbol(sym_plain, disp_plain);
    end else begin
      pair.neg = pack_symbol(sym_plain, disp_plain);
      pair.pos = pack_symbol(sym_inv, disp_inv);
    end
    return pair;
  endfunction

  function automatic palette_words_t predict_palette_words(input logic [31:0] item);
    logic [tpse_pkg::CHAN_W-1:0] blue;
    logic [tpse_pkg::CHAN_W-1:0] green;
    logic [tpse_pkg::CHAN_W-1:0] red;
    tpse_pkg::sym_pair_t         pair;
    palette_words_t              w;
    if (colour_format == tpse_pkg::FMT_RGB888) begin
      blue = item[7:0];
      green = item[15:8];
      red = item[23:16];
    end else begin
      // widen 565 fields, low bits zero; bits 23:16 play no part
      blue = {item[4:0], 3'b000};
      green = {item[10:5], 2'b00};
      red = {item[15:11], 3'b000};
    end
    w.entry = item[31:24];
    pair = encode_tmds_pair(blue);
    w.blue_neg = pair.neg;
    w.blue_pos = pair.pos;
    pair = encode_tmds_pair(green);
    w.green_neg = pair.neg;
    w.green_pos = pair.pos;
    pair = encode_tmds_pair(red);
    w.red_neg = pair.neg;
    w.red_pos = pair.pos;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk) begin
    palette_words_t got;
    palette_words_t want;
    if (!rst_n) begin
      colour_format = tpse_pkg::FMT_RGB565;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_words.size() == 0) begin
          report_mismatch("result with nothing outstanding, entry", 32'(got.entry), '0);
        end else begin
          want = expected_words.pop_front();
          check_field("entry_out", 32'(got.entry), 32'(want.entry));
          check_field("blue_negative_word", got.blue_neg, want.blue_neg);
          check_field("blue_positive_word", got.blue_pos, want.blue_pos);
          check_field("green_negative_word", got.green_neg, want.green_neg);
          check_field("green_positive_word", got.green_pos, want.green_pos);
          check_field("red_negative_word", got.red_neg, want.red_neg);
          check_field("red_positive_word", got.red_pos, want.red_pos);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(predict_palette_words(in_tdata));
      end
      if (cfg_valid && cfg_ready) begin
        colour_format = cfg_data;
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  wire          in_tready;
  logic [31:0]  in_tdata;   // colour[23:0], entry_index[31:24]
  wire          out_tvalid;
  logic         out_tready;
  // entry_out[7:0], blue_negative_word[39:8], blue_positive_word[71:40],
  // green_negative_word[103:72], green_positive_word[135:104],
  // red_negative_word[167:136], red_positive_word[199:168]
  wire  [199:0] out_tdata;
  logic         cfg_valid;
  wire          cfg_ready;
  logic         cfg_data;

  int fail_count;
  int pending;
  int in_idle_pct;
  int out_stall_pct;
  int hold_requests;

  tmds_palette_symbol_pair_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  symbol_pair_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Offer one palette entry and hold it until the transfer
  task automatic send_colour(input logic [23:0] colour, input logic [7:0] entry);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {entry, colour};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drain the pipeline, then write colour_format
  task automatic set_format(input logic fmt);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= fmt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic fmt, input int idle_pct, input int stall_pct,
                           input int count, input bit long_hold);
    set_format(fmt);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    if (long_hold) begin
      hold_requests++;
    end
    repeat (count) begin
      send_colour(24'($urandom), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    rst_n = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_requests = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 565: field extremes, ignored top byte, single fields
    set_format(tpse_pkg::FMT_RGB565);
    send_colour(24'h000000, 8'd0);
    send_colour(24'h00FFFF, 8'd255);
    send_colour(24'hFF0000, 8'd1);
    send_colour(24'hFFFFFF, 8'd128);
    send_colour(24'h00001F, 8'd2);
    send_colour(24'h0007E0, 8'd3);
    send_colour(24'h00F800, 8'd4);
    send_colour(24'h00001E, 8'd5);
    send_colour(24'h000540, 8'd6);

    // 888: balanced bytes with either low bit, sparse and dense bytes
    set_format(tpse_pkg::FMT_RGB888);
    send_colour(24'h000000, 8'd255);
    send_colour(24'hFFFFFF, 8'd0);
    send_colour(24'h55AAF0, 8'd7);
    send_colour(24'h0FCC33, 8'd8);
    send_colour(24'h01FE80, 8'd9);
    send_colour(24'h7F1008, 8'd10);
    send_colour(24'hFF00FF, 8'd11);
    send_colour(24'h123456, 8'd12);
    send_colour(24'hE10F96, 8'd13);

    run_phase(tpse_pkg::FMT_RGB888, 0, 0, 320, 1'b0);
    run_phase(tpse_pkg::FMT_RGB565, 79, 0, 320, 1'b0);
    run_phase(tpse_pkg::FMT_RGB888, 0, 79, 320, 1'b1);
    run_phase(tpse_pkg::FMT_RGB565, 24, 24, 320, 1'b0);
    run_phase(tpse_pkg::FMT_RGB888, 24, 24, 320, 1'b0);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
